// ----- design/crt_pkg.sv -----
// Shared constants, codes, types and helpers of the counter rate tracker.
`timescale 1ns / 1ps
package crt_pkg;

  localparam int ROW_W   = 10;
  localparam int VAL_W   = 64;
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 2;
  localparam int RATE_W  = 32;
  localparam int STAT_W  = 2;
  localparam int STEP_W  = $clog2(ROW_W);

  // Counter mode codes; the third and fourth codes behave as a 64-bit counter.
  localparam logic [MODE_W-1:0] MODE_GAUGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CNT32 = 2'd1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_EMIT      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNPRIMED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER      = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_TIME = 2'd3;

  localparam logic [VAL_W-1:0] WRAP32_ADD = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
  } crt_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_CALC,
    S_DIV,
    S_DONE
  } crt_state_t;

  // Status of a finished rate against the speed limit.
  function automatic logic [STAT_W-1:0] rate_status(input logic [RATE_W-1:0] rate,
                                                     input logic [VAL_W-1:0]  limit);
    logic below;
    below = (limit[VAL_W-1:RATE_W] != '0) || (rate < limit[RATE_W-1:0]);
    return below ? ST_EMIT : ST_OVER;
  endfunction

endpackage

// ----- design/crt_sample_if.sv -----
// Valid/ready channel carrying one counter sample.
`timescale 1ns / 1ps
interface crt_sample_if;
  import crt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_index;
  logic [VAL_W-1:0]    sample_value;
  logic [TIME_W-1:0]   sample_time;
  logic [MODE_W-1:0]   counter_mode;
  logic [VAL_W-1:0]    speed_limit;

  modport source (output valid, row_index, sample_value, sample_time, counter_mode,
                  speed_limit, input ready);
  modport sink   (input valid, row_index, sample_value, sample_time, counter_mode,
                  speed_limit, output ready);
endinterface

// ----- design/crt_result_if.sv -----
// Valid/ready channel carrying one delta and rate result.
`timescale 1ns / 1ps
interface crt_result_if;
  import crt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_echo;
  logic [VAL_W-1:0]    delta_value;
  logic [RATE_W-1:0]   rate_value;
  logic [STAT_W-1:0]   status;

  modport source (output valid, row_echo, delta_value, rate_value, status, input ready);
  modport sink   (input valid, row_echo, delta_value, rate_value, status, output ready);
endinterface

// ----- design/counter_rate_tracker_top.sv -----
// Counter rate tracker: per-row delta and rate of polled counter samples.
//
// Samples enter on the sample channel, one result per sample leaves on the result
// channel, both valid/ready; a transaction completes when valid and ready are high.
// Each row's last value and timestamp live in one synchronous memory that is read,
// updated and written back while the sample is worked on, one sample at a time.
// A gauge, unprimed or zero-time sample skips the division; otherwise the rate is
// computed in the radix-2 divider, one quotient bit per cycle. A ROW_COUNT below
// 1024 adds a reduction of the row index modulo ROW_COUNT before the memory read.
// The next sample can be taken in the cycle after the previous result is loaded
// into the output register.
// After reset the memory is swept to zero, one row per cycle, over all ROW_COUNT rows;
// sample.ready stays low meanwhile. A stalled result holds in the output register;
// the next sample is still taken and worked on, and waits at its end until the
// output register frees.
`timescale 1ns / 1ps
module counter_rate_tracker_top #(
  parameter int ROW_COUNT = 1024
) (
  input  logic         clk,
  input  logic         rst,
  crt_sample_if.sink   sample,
  crt_result_if.source result
);
  import crt_pkg::*;

  localparam int AW       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int XW       = (AW > ROW_W) ? AW : ROW_W;
  localparam bit SKIP_MOD = ROW_COUNT >= (1 << ROW_W);
  localparam logic [31:0] ROWS_32 = 32'(ROW_COUNT);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROW_W - 1);

  crt_state_t state, state_next;

  logic [ROW_W-1:0]  row_raw;
  logic [ROW_W-1:0]  row_rem;
  logic [STEP_W-1:0] step;
  logic [VAL_W-1:0]  smp_value;
  logic [TIME_W-1:0] smp_time;
  logic [MODE_W-1:0] smp_mode;
  logic [VAL_W-1:0]  smp_limit;
  logic [VAL_W-1:0]  res_delta;
  logic [RATE_W-1:0] res_rate;
  logic [STAT_W-1:0] res_status;

  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic              div_start;
  logic              load_out;
  logic              clr_busy;
  logic              div_done;
  logic [RATE_W-1:0] quotient;
  logic [AW-1:0]     addr;
  logic [XW-1:0]     row_ext;
  crt_entry_t        rd_data;
  crt_entry_t        wr_data;

  logic [31:0]       sub_step;
  logic              sub_fits;
  logic [VAL_W-1:0]  diff;
  logic [TIME_W-1:0] elapsed;

  assign row_ext  = XW'(row_rem);
  assign addr     = row_ext[AW-1:0];
  assign sub_step = ROWS_32 << step;
  assign sub_fits = 32'(row_rem) >= sub_step;
  assign wr_data  = '{value: smp_value, stamp: smp_time};
  assign elapsed  = smp_time - rd_data.stamp;

  always_comb begin
    diff = smp_value - rd_data.value;
    if (smp_mode == MODE_CNT32 && rd_data.value > smp_value) begin
      diff = diff + WRAP32_ADD;
    end
  end

  assign sample.ready = (state == S_IDLE) && !clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sample.valid && !clr_busy) begin
          accept     = 1'b1;
          state_next = SKIP_MOD ? S_READ : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (step == '0) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        wr_en = 1'b1;
        if (smp_mode != MODE_GAUGE && rd_data.stamp != '0 && elapsed != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sample hold, row reduction and result assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_raw   <= sample.row_index;
      row_rem   <= sample.row_index;
      step      <= LAST_STEP;
      smp_value <= sample.sample_value;
      smp_time  <= sample.sample_time;
      smp_mode  <= sample.counter_mode;
      smp_limit <= sample.speed_limit;
    end
    if (state == S_REDUCE) begin
      step <= step - 1'b1;
      if (sub_fits) begin
        row_rem <= row_rem - sub_step[ROW_W-1:0];
      end
    end
    if (state == S_CALC) begin
      priority if (smp_mode == MODE_GAUGE) begin
        res_delta  <= smp_value;
        res_rate   <= smp_value[RATE_W-1:0];
        res_status <= rate_status(smp_value[RATE_W-1:0], smp_limit);
      end else if (rd_data.stamp == '0) begin
        res_delta  <= '0;
        res_rate   <= '0;
        res_status <= ST_UNPRIMED;
      end else if (elapsed == '0) begin
        res_delta  <= diff;
        res_rate   <= '0;
        res_status <= ST_ZERO_TIME;
      end else begin
        res_delta  <= diff;
      end
    end
    if (state == S_DIV && div_done) begin
      res_rate   <= quotient;
      res_status <= rate_status(quotient, smp_limit);
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.row_echo    <= row_raw;
      result.delta_value <= res_delta;
      result.rate_value  <= res_rate;
      result.status      <= res_status;
    end
  end

  crt_store #(
    .ROW_COUNT (ROW_COUNT),
    .AW        (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  crt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ----- design/crt_store.sv -----
// Per-row store of last counter value and timestamp, with a clearing pass after reset.
`timescale 1ns / 1ps
module crt_store #(
  parameter int ROW_COUNT = 1024,
  parameter int AW        = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output crt_pkg::crt_entry_t rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  crt_pkg::crt_entry_t wr_data,
  output logic               clr_busy
);
  import crt_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(ROW_COUNT - 1);

  crt_entry_t    mem [ROW_COUNT];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/crt_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, low 32 quotient bits.
`timescale 1ns / 1ps
module crt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [crt_pkg::VAL_W-1:0]  dividend,
  input  logic [crt_pkg::TIME_W-1:0] divisor,
  output logic                       done,
  output logic [crt_pkg::RATE_W-1:0] quotient
);
  import crt_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [TIME_W:0]  rem;
  logic [VAL_W-1:0] dq;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W:0]  shifted;
  logic             fits;

  // Partial remainder stays below the divisor, so 33 bits hold the shifted value.
  assign shifted  = {rem[TIME_W-1:0], dq[VAL_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = dq[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VAL_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      dq  <= {dq[VAL_W-2:0], fits};
    end
  end

endmodule
